>>> rtl/pqsm_pkg.sv
// Package: shared types and constants for the priority queue with service match.
package pqsm_pkg;

  localparam logic [3:0] UNIT_LIMIT_RESET = 4'd10;

  typedef enum logic [1:0] {
    KIND_ENQUEUE  = 2'd0,
    KIND_DISPATCH = 2'd1,
    KIND_COMPLETE = 2'd2,
    KIND_NONE     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_NOMATCH = 2'd2,
    ST_NOOP    = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] tag;
    logic [3:0] prio;
    logic [4:0] mask;
  } job_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] job_tag;
    logic [3:0] job_priority;
    logic [4:0] service_mask;
    logic [2:0] service_id;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_tag;
    logic [3:0] out_priority;
    logic [4:0] out_mask;
    logic [3:0] units_left;
    logic [4:0] queue_count;
  } rsp_t;

  typedef struct packed {
    logic       enq;
    logic       deq;
    job_t       new_job;
    logic [4:0] svc_sel;
  } cell_ctl_t;

  typedef struct packed {
    logic       dec;
    logic       inc;
    logic [2:0] svc;
  } units_ctl_t;

endpackage

>>> rtl/priority_queue_service_match.sv
// Top level: stable priority job queue with per-service match dispatch.
//
//   channel  direction  payload  handshake
//   req      in         req_t    req_valid / req_ready
//   rsp      out        rsp_t    rsp_valid / rsp_ready
//   cfg      in         [3:0]    cfg_valid / cfg_ready (always ready)
//
// Each request is registered first; then the cell row inserts or removes and
// the response register loads.
// The match search ripples combinationally through the row of QUEUE_DEPTH cells.
// A waiting response holds the request register; req_ready drops until it drains.
// Reset clears the job count and loads every service with 10 units.
module priority_queue_service_match
  import pqsm_pkg::*;
#(
  parameter int QUEUE_DEPTH   = 16,
  parameter int SERVICE_TYPES = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  output logic       req_ready,
  input  req_t       req,
  output logic       rsp_valid,
  input  logic       rsp_ready,
  output rsp_t       rsp,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [3:0] cfg_data
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [4:0] SVC_LIM = 5'(SERVICE_TYPES);

  req_t            cmd;
  logic            cmd_valid;
  logic            fire;
  logic [3:0]      unit_limit;
  logic [CW-1:0]   count;
  logic [CW-1:0]   count_next;
  logic            full;
  logic            svc_ok;
  logic            is_enq;
  logic            is_disp;
  logic            is_comp;
  cell_ctl_t       cctl;
  units_ctl_t      uctl;
  logic [3:0]      level;
  rsp_t            rsp_next;

  job_t            cell_job  [QUEUE_DEPTH];
  job_t            left_job  [QUEUE_DEPTH];
  job_t            right_job [QUEUE_DEPTH];
  logic            go_chain    [QUEUE_DEPTH+1];
  logic            found_chain [QUEUE_DEPTH+1];
  job_t            carry_chain [QUEUE_DEPTH+1];

  assign req_ready = !cmd_valid;
  assign cfg_ready = 1'b1;
  assign fire      = cmd_valid && (!rsp_valid || rsp_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_limit <= UNIT_LIMIT_RESET;
    end else if (cfg_valid) begin
      unit_limit <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (req_valid && req_ready) begin
      cmd_valid <= 1'b1;
    end else if (fire) begin
      cmd_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= req;
    end
  end

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign svc_ok  = ({2'b00, cmd.service_id} < SVC_LIM);
  assign is_enq  = (cmd.kind == KIND_ENQUEUE);
  assign is_disp = (cmd.kind == KIND_DISPATCH) && svc_ok;
  assign is_comp = (cmd.kind == KIND_COMPLETE) && svc_ok;

  assign cctl.enq          = fire && is_enq && !full;
  assign cctl.deq          = fire && is_disp;
  assign cctl.new_job.tag  = cmd.job_tag;
  assign cctl.new_job.prio = cmd.job_priority;
  assign cctl.new_job.mask = cmd.service_mask;
  assign cctl.svc_sel      = 5'd1 << cmd.service_id;

  assign go_chain[0]    = 1'b0;
  assign found_chain[0] = 1'b0;
  assign carry_chain[0] = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_job[i] = cell_job[i];
    end else begin : g_mid_l
      assign left_job[i] = cell_job[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right_job[i] = cell_job[i];
    end else begin : g_mid_r
      assign right_job[i] = cell_job[i+1];
    end

    pqsm_cell u_cell (
      .clk       (clk),
      .ctl       (cctl),
      .occupied  (count > CW'(i)),
      .left_job  (left_job[i]),
      .right_job (right_job[i]),
      .left_go   (go_chain[i]),
      .found_in  (found_chain[i]),
      .carry_in  (carry_chain[i]),
      .job       (cell_job[i]),
      .go        (go_chain[i+1]),
      .found_out (found_chain[i+1]),
      .carry_out (carry_chain[i+1])
    );
  end

  assign uctl.dec = fire && is_disp && found_chain[QUEUE_DEPTH];
  assign uctl.inc = fire && is_comp;
  assign uctl.svc = cmd.service_id;

  pqsm_units #(
    .SERVICE_TYPES (SERVICE_TYPES)
  ) u_units (
    .clk        (clk),
    .rst        (rst),
    .unit_limit (unit_limit),
    .ctl        (uctl),
    .level      (level)
  );

  always_comb begin
    count_next = count;
    rsp_next   = '0;
    unique case (cmd.kind)
      KIND_ENQUEUE: begin
        if (full) begin
          rsp_next.status = ST_FULL;
        end else begin
          rsp_next.status = ST_DONE;
          count_next      = count + CW'(1);
        end
      end
      KIND_DISPATCH: begin
        if (!svc_ok) begin
          rsp_next.status = ST_NOOP;
        end else if (found_chain[QUEUE_DEPTH]) begin
          rsp_next.status       = ST_DONE;
          rsp_next.out_tag      = carry_chain[QUEUE_DEPTH].tag;
          rsp_next.out_priority = carry_chain[QUEUE_DEPTH].prio;
          rsp_next.out_mask     = carry_chain[QUEUE_DEPTH].mask;
          rsp_next.units_left   = level;
          count_next            = count - CW'(1);
        end else begin
          rsp_next.status     = ST_NOMATCH;
          rsp_next.units_left = level;
        end
      end
      KIND_COMPLETE: begin
        if (svc_ok) begin
          rsp_next.status     = ST_DONE;
          rsp_next.units_left = level;
        end else begin
          rsp_next.status = ST_NOOP;
        end
      end
      default: begin
        rsp_next.status = ST_NOOP;
      end
    endcase
    rsp_next.queue_count = 5'(count_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else if (fire) begin
      count     <= count_next;
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      rsp <= rsp_next;
    end
  end

endmodule

>>> rtl/pqsm_cell.sv
// One queue slot: holds a job and shifts it for insert or removal.
module pqsm_cell
  import pqsm_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  logic      occupied,
  input  job_t      left_job,
  input  job_t      right_job,
  input  logic      left_go,
  input  logic      found_in,
  input  job_t      carry_in,
  output job_t      job,
  output logic      go,
  output logic      found_out,
  output job_t      carry_out
);

  logic hit;

  assign go        = !occupied || (job.prio < ctl.new_job.prio);
  assign hit       = occupied && (|(job.mask & ctl.svc_sel));
  assign found_out = found_in || hit;
  assign carry_out = found_in ? carry_in : job;

  always_ff @(posedge clk) begin
    if (ctl.enq) begin
      if (left_go) begin
        job <= left_job;
      end else if (go) begin
        job <= ctl.new_job;
      end
    end else if (ctl.deq && found_out) begin
      job <= right_job;
    end
  end

endmodule

>>> rtl/pqsm_units.sv
// Per-service unit counters with saturating take and return.
module pqsm_units
  import pqsm_pkg::*;
#(
  parameter int SERVICE_TYPES = 5
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [3:0] unit_limit,
  input  units_ctl_t ctl,
  output logic [3:0] level
);

  logic [3:0] units [SERVICE_TYPES];
  logic [3:0] cur;
  logic [SERVICE_TYPES-1:0] sel;

  always_comb begin
    cur = '0;
    for (int s = 0; s < SERVICE_TYPES; s++) begin
      sel[s] = ({1'b0, ctl.svc} == 4'(s));
      if (sel[s]) begin
        cur = units[s];
      end
    end
    if (ctl.dec) begin
      level = (cur != 4'd0) ? cur - 4'd1 : cur;
    end else if (ctl.inc) begin
      level = (cur < unit_limit) ? cur + 4'd1 : cur;
    end else begin
      level = cur;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < SERVICE_TYPES; s++) begin
      if (rst) begin
        units[s] <= UNIT_LIMIT_RESET;
      end else if (sel[s] && (ctl.dec || ctl.inc)) begin
        units[s] <= level;
      end
    end
  end

endmodule

>>> test/pqsm_checker.sv
// Checker: predicts and scores every response of the priority queue with service match.
`timescale 1ns / 1ps

module pqsm_checker
  import pqsm_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       req_valid,
  input  logic       req_ready,
  input  req_t       req,
  input  logic       rsp_valid,
  input  logic       rsp_ready,
  input  rsp_t       rsp,
  input  logic       cfg_valid,
  input  logic       cfg_ready,
  input  logic [3:0] cfg_data,
  output int         outstanding,
  output int         mismatches
);

  localparam int QUEUE_DEPTH   = 16;
  localparam int SERVICE_TYPES = 5;

  job_t       jobs [QUEUE_DEPTH];
  int         job_count;
  logic [3:0] units [SERVICE_TYPES];
  logic [3:0] unit_limit;
  rsp_t       expected_rsp [$];

  function automatic void clear_queue_state();
    job_count  = 0;
    unit_limit = UNIT_LIMIT_RESET;
    for (int s = 0; s < SERVICE_TYPES; s++) units[s] = UNIT_LIMIT_RESET;
  endfunction

  function automatic rsp_t serve_request(req_t r);
    rsp_t       res;
    int         i;
    int         pos;
    int         hit;
    job_t       j;
    logic [2:0] svc;
    res = '0;
    svc = r.service_id;
    if (r.kind == KIND_ENQUEUE) begin
      if (job_count >= QUEUE_DEPTH) begin
        res.status = ST_FULL;
      end else begin
        pos = job_count;
        for (i = 0; i < job_count; i++) begin
          if (jobs[i].prio < r.job_priority) begin
            pos = i;
            break;
          end
        end
        for (i = job_count; i > pos; i--) jobs[i] = jobs[i - 1];
        jobs[pos].tag  = r.job_tag;
        jobs[pos].prio = r.job_priority;
        jobs[pos].mask = r.service_mask;
        job_count++;
        res.status = ST_DONE;
      end
    end else if (r.kind == KIND_NONE || svc >= SERVICE_TYPES) begin
      res.status = ST_NOOP;
    end else if (r.kind == KIND_DISPATCH) begin
      hit = -1;
      for (i = 0; i < job_count; i++) begin
        if (jobs[i].mask[svc]) begin
          hit = i;
          break;
        end
      end
      if (hit < 0) begin
        res.status     = ST_NOMATCH;
        res.units_left = units[svc];
      end else begin
        j = jobs[hit];
        for (i = hit; i < job_count - 1; i++) jobs[i] = jobs[i + 1];
        job_count--;
        if (units[svc] != 4'd0) units[svc] = units[svc] - 4'd1;
        res.status       = ST_DONE;
        res.out_tag      = j.tag;
        res.out_priority = j.prio;
        res.out_mask     = j.mask;
        res.units_left   = units[svc];
      end
    end else begin
      if (units[svc] < unit_limit) units[svc] = units[svc] + 4'd1;
      res.status     = ST_DONE;
      res.units_left = units[svc];
    end
    res.queue_count = job_count[4:0];
    return res;
  endfunction

  task automatic compare_response(rsp_t want, rsp_t got);
    logic [7:0] e [6];
    logic [7:0] a [6];
    string      names [6];
    names = '{"status", "out_tag", "out_priority", "out_mask", "units_left", "queue_count"};
    e = '{want.status, want.out_tag, want.out_priority, want.out_mask, want.units_left,
          want.queue_count};
    a = '{got.status, got.out_tag, got.out_priority, got.out_mask, got.units_left,
          got.queue_count};
    for (int k = 0; k < 6; k++) begin
      if (a[k] !== e[k]) begin
        mismatches++;
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, names[k], e[k], a[k]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_queue_state();
      expected_rsp.delete();
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (expected_rsp.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected response transaction, expected none, actual %h",
                   $time, rsp);
        end else begin
          compare_response(expected_rsp.pop_front(), rsp);
        end
      end
      if (req_valid && req_ready) expected_rsp.push_back(serve_request(req));
      if (cfg_valid && cfg_ready) unit_limit = cfg_data;
    end
    outstanding = expected_rsp.size();
  end

endmodule

>>> test/tb_priority_queue_service_match.sv
// Testbench top: drives requests, limit writes and response stalls, and reports the verdict.
`timescale 1ns / 1ps

module tb_priority_queue_service_match;
  import pqsm_pkg::*;

  localparam int PHASE_ITEMS = 190;

  logic       clk;
  logic       rst;
  logic       req_valid;
  logic       req_ready;
  req_t       req;
  logic       rsp_valid;
  logic       rsp_ready;
  rsp_t       rsp;
  logic       cfg_valid;
  logic       cfg_ready;
  logic [3:0] cfg_data;
  int         outstanding;
  int         mismatches;
  bit         steady;

  priority_queue_service_match dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  pqsm_checker u_checker (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_ready   (req_ready),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_ready   (rsp_ready),
    .rsp         (rsp),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int idle_length();
    int w;
    w = $urandom_range(0, 99);
    if (w < 55) return 0;
    if (w < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    int g;
    rsp_ready = 1'b0;
    forever begin
      @(negedge clk);
      rsp_ready = 1'b1;
      repeat ($urandom_range(0, 3) == 0 ? $urandom_range(30, 120) : $urandom_range(0, 12))
        @(negedge clk);
      g = idle_length();
      if (g > 0) begin
        rsp_ready = 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  function automatic req_t make_request(kind_t k, int tag, int prio, int mask, int svc);
    req_t r;
    r.kind         = k;
    r.job_tag      = tag[7:0];
    r.job_priority = prio[3:0];
    r.service_mask = mask[4:0];
    r.service_id   = svc[2:0];
    return r;
  endfunction

  function automatic req_t random_request(bit filling);
    req_t r;
    int   w;
    r.job_tag      = 8'($urandom_range(0, 255));
    r.job_priority = 4'(($urandom_range(0, 1) == 0) ? $urandom_range(0, 15)
                                                     : $urandom_range(6, 8));
    w = $urandom_range(0, 9);
    if (w < 6) r.service_mask = 5'd1 << $urandom_range(0, 4);
    else r.service_mask = 5'($urandom_range(0, 31));
    r.service_id = 3'(($urandom_range(0, 19) == 0) ? $urandom_range(5, 7)
                                                   : $urandom_range(0, 4));
    w = $urandom_range(0, 99);
    if (filling) begin
      if (w < 55) r.kind = KIND_ENQUEUE;
      else if (w < 80) r.kind = KIND_DISPATCH;
      else if (w < 96) r.kind = KIND_COMPLETE;
      else r.kind = KIND_NONE;
    end else begin
      if (w < 15) r.kind = KIND_ENQUEUE;
      else if (w < 70) r.kind = KIND_DISPATCH;
      else if (w < 96) r.kind = KIND_COMPLETE;
      else r.kind = KIND_NONE;
    end
    return r;
  endfunction

  task automatic send_request(req_t r);
    int g;
    g = steady ? 0 : idle_length();
    if (g > 0) begin
      req_valid = 1'b0;
      repeat (g) @(negedge clk);
    end
    req       = r;
    req_valid = 1'b1;
    do @(posedge clk); while (!req_ready);
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    req_valid = 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic load_unit_limit(logic [3:0] limit);
    wait_for_drain();
    cfg_data  = limit;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  initial begin
    logic [3:0] limits [6];
    bit         filling;
    rst       = 1'b1;
    req_valid = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    steady    = 1'b0;
    filling   = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_request(make_request(KIND_DISPATCH, 0, 0, 0, 0));
    send_request(make_request(KIND_COMPLETE, 0, 0, 0, 0));
    send_request(make_request(KIND_ENQUEUE, 0, 0, 0, 0));
    send_request(make_request(KIND_ENQUEUE, 255, 15, 31, 7));
    send_request(make_request(KIND_ENQUEUE, 1, 15, 1, 0));
    send_request(make_request(KIND_ENQUEUE, 2, 7, 16, 0));
    send_request(make_request(KIND_ENQUEUE, 3, 7, 2, 0));
    send_request(make_request(KIND_DISPATCH, 85, 5, 10, 0));
    send_request(make_request(KIND_DISPATCH, 0, 0, 0, 0));
    send_request(make_request(KIND_DISPATCH, 0, 0, 0, 4));
    send_request(make_request(KIND_DISPATCH, 0, 0, 0, 1));
    send_request(make_request(KIND_DISPATCH, 0, 0, 0, 2));
    send_request(make_request(KIND_DISPATCH, 0, 0, 31, 5));
    send_request(make_request(KIND_DISPATCH, 0, 0, 0, 7));
    send_request(make_request(KIND_COMPLETE, 0, 0, 0, 6));
    send_request(make_request(KIND_NONE, 255, 15, 31, 7));
    send_request(make_request(KIND_COMPLETE, 0, 0, 0, 4));
    send_request(make_request(KIND_ENQUEUE, 170, 8, 24, 7));
    send_request(make_request(KIND_DISPATCH, 90, 12, 21, 3));
    send_request(make_request(KIND_COMPLETE, 255, 15, 31, 0));

    limits = '{4'd15, 4'd0, 4'd1, 4'd10, 4'd7, 4'($urandom_range(0, 15))};
    foreach (limits[p]) begin
      load_unit_limit(limits[p]);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 16 == 0) filling = ($urandom_range(0, 1) == 1);
        if (n % 40 == 0) steady = ($urandom_range(0, 3) == 0);
        send_request(random_request(filling));
      end
      steady = 1'b0;
    end

    wait_for_drain();
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
